[rtl/gps_pkg.sv]
// Shared types, constants and byte tables for the gamepad poll sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package gps_pkg;

    // Frame geometry
    localparam int FRAME_BYTES = 21;
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);
    localparam int ST_IDX_W    = $clog2(FRAME_BYTES);

    // Fixed string lengths and frame byte positions
    localparam logic [POS_W-1:0] ENTER_LEN   = POS_W'(5);
    localparam logic [POS_W-1:0] CFG_LEN     = POS_W'(9);
    localparam logic [POS_W-1:0] SHORT_FRAME = POS_W'(9);
    localparam logic [POS_W-1:0] FULL_FRAME  = POS_W'(FRAME_BYTES);
    localparam logic [POS_W-1:0] MODE_KNOWN  = POS_W'(2);
    localparam int MODE_BYTE   = 1;
    localparam int BTN_LO_BYTE = 3;
    localparam int BTN_HI_BYTE = 4;

    localparam logic [7:0]  MODE_FULL   = 8'h79;
    localparam logic [15:0] LIMIT_RESET = 16'd1500;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_POLL = 2'd1,
        CMD_XCHG = 2'd2,
        CMD_READ = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ENTER   = 3'd1,
        PH_SETMODE = 3'd2,
        PH_EXIT    = 3'd3,
        PH_POLL    = 3'd4
    } t_phase;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic [4:0] index;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        attention;
        logic        release_after;
        logic        frame_done;
        logic [15:0] held_mask;
        logic [15:0] pressed_mask;
        logic [15:0] released_mask;
        logic [7:0]  mode_id;
        logic [7:0]  read_data;
    } t_out_item;

    // Length of the string that the phase sends; poll length follows the mode byte
    function automatic logic [POS_W-1:0] phase_len(t_phase ph, logic [POS_W-1:0] pos,
                                                   logic [7:0] mode);
        logic [POS_W-1:0] len;
        unique case (ph)
            PH_ENTER:           len = ENTER_LEN;
            PH_SETMODE, PH_EXIT: len = CFG_LEN;
            PH_POLL:            len = (pos >= MODE_KNOWN && mode == MODE_FULL) ?
                                      FULL_FRAME : SHORT_FRAME;
            default:            len = '0;
        endcase
        return len;
    endfunction

    // Command byte pending at a given position of each string
    function automatic logic [7:0] pending_byte(t_phase ph, logic [POS_W-1:0] pos);
        logic [7:0] b;
        b = 8'h00;
        unique case (ph)
            PH_ENTER: begin
                if (pos == POS_W'(0))      b = 8'h01;
                else if (pos == POS_W'(1)) b = 8'h43;
                else if (pos == POS_W'(3)) b = 8'h01;
            end
            PH_SETMODE: begin
                if (pos == POS_W'(0))      b = 8'h01;
                else if (pos == POS_W'(1)) b = 8'h44;
                else if (pos == POS_W'(3)) b = 8'h01;
                else if (pos == POS_W'(4)) b = 8'h03;
            end
            PH_EXIT: begin
                if (pos == POS_W'(0))      b = 8'h01;
                else if (pos == POS_W'(1)) b = 8'h43;
                else if (pos >= POS_W'(4) && pos < CFG_LEN) b = 8'h5A;
            end
            PH_POLL: begin
                if (pos == POS_W'(0))      b = 8'h01;
                else if (pos == POS_W'(1)) b = 8'h42;
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[rtl/gamepad_poll_sequencer_unit.sv]
// Top level of the gamepad poll sequencer: core state logic and result buffer.
// Depends on gps_pkg, gps_core and gps_out_buf.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one command
//   per transfer: ms tick, start poll, byte exchanged (with rx_byte), or frame
//   byte read (with index). Every accepted item yields exactly one result on
//   the output channel (o_out_valid / i_out_stall / o_out_data): the next byte
//   to shift out, select control, frame completion, button masks, mode byte
//   and read data.
//   Each result is registered in gps_out_buf after its input transfer; one
//   item per cycle is sustained while o_in_stall is low, set by the state
//   update in gps_core. When the receiver stalls, one further result is held
//   in a skid entry; o_in_stall rises only when that entry is occupied and
//   drops the cycle after the output is taken.
//   The reconfiguration limit is written through i_cfg_we / i_cfg_wdata; the
//   user must do so only while the block is idle, which it does not enforce.
//   Synchronous reset returns the sequencer to idle, clears the frame store,
//   button history and ms counter, sets the limit to 1500, and empties the
//   result buffer.
`default_nettype none

module gamepad_poll_sequencer_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire gps_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output gps_pkg::t_out_item      o_out_data,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_wdata
);
    import gps_pkg::*;

    logic      in_xfer;
    t_out_item result;

    assign in_xfer = i_in_valid && !o_in_stall;

    gps_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_xfer),
        .i_item      (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (result)
    );

    gps_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_xfer),
        .i_data  (result),
        .o_full  (o_in_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

    // Skid entry only fills behind a held output
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    // Taking the output frees the skid entry
    a_stall_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_stall && !i_out_stall) |=> !o_in_stall)
        else $error("skid entry not drained after output transfer");

    // Frame completion returns to idle with select released
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_done) |-> !o_out_data.attention)
        else $error("frame done while select still asserted");

    // Release flag only on a pending byte
    a_release_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.release_after) |-> o_out_data.attention)
        else $error("release flagged while idle");

endmodule

`default_nettype wire

[rtl/gps_core.sv]
// Sequencer state, frame store and per-item result logic.
// Depends on gps_pkg.
`default_nettype none

module gps_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire gps_pkg::t_in_item  i_item,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_wdata,
    output gps_pkg::t_out_item      o_result
);
    import gps_pkg::*;

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_store [FRAME_BYTES];
    logic [7:0]       n_store [FRAME_BYTES];
    logic [15:0]      r_elapsed, n_elapsed;
    logic [15:0]      r_raw, n_raw;
    logic [15:0]      r_prev, n_prev;
    logic [15:0]      r_limit;

    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] out_len;
    logic [7:0]       rd;
    logic             done;
    logic             busy;
    logic [15:0]      chg;

    // Next state for the item at the input
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_store   = r_store;
        n_elapsed = r_elapsed;
        n_raw     = r_raw;
        n_prev    = r_prev;
        done      = 1'b0;
        rd        = 8'h00;
        pos_inc   = r_pos + POS_W'(1);
        unique case (t_cmd'(i_item.cmd))
            CMD_TICK: begin
                if (r_elapsed != 16'hFFFF) n_elapsed = r_elapsed + 16'd1;
            end
            CMD_POLL: begin
                if (r_phase == PH_IDLE) begin
                    n_pos = '0;
                    if (r_elapsed > r_limit) begin
                        n_phase = PH_ENTER;
                    end else begin
                        n_phase = PH_POLL;
                        n_prev  = r_raw;
                    end
                end
            end
            CMD_XCHG: begin
                if (r_phase != PH_IDLE) begin
                    if (r_phase == PH_POLL && r_pos < FULL_FRAME)
                        n_store[r_pos[ST_IDX_W-1:0]] = i_item.rx_byte;
                    n_pos = pos_inc;
                    if (pos_inc >= phase_len(r_phase, pos_inc, n_store[MODE_BYTE])) begin
                        n_pos = '0;
                        priority case (r_phase)
                            PH_ENTER:   n_phase = PH_SETMODE;
                            PH_SETMODE: n_phase = PH_EXIT;
                            PH_EXIT: begin
                                n_phase = PH_POLL;
                                n_prev  = r_raw;
                            end
                            default: begin
                                n_raw     = {n_store[BTN_HI_BYTE], n_store[BTN_LO_BYTE]};
                                n_elapsed = '0;
                                n_phase   = PH_IDLE;
                                done      = 1'b1;
                            end
                        endcase
                    end
                end
            end
            CMD_READ: begin
                if (int'(i_item.index) < FRAME_BYTES)
                    rd = r_store[i_item.index[ST_IDX_W-1:0]];
            end
            default: ;
        endcase
    end

    // Result as seen after the item
    always_comb begin
        busy    = (n_phase != PH_IDLE);
        out_len = phase_len(n_phase, n_pos, n_store[MODE_BYTE]);
        chg     = n_prev ^ n_raw;
        o_result.tx_byte       = busy ? pending_byte(n_phase, n_pos) : 8'h00;
        o_result.attention     = busy;
        o_result.release_after = busy && ((n_pos + POS_W'(1)) == out_len);
        o_result.frame_done    = done;
        o_result.held_mask     = ~n_raw;
        o_result.pressed_mask  = chg & ~n_raw;
        o_result.released_mask = chg & ~n_prev;
        o_result.mode_id       = n_store[MODE_BYTE];
        o_result.read_data     = rd;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pos     <= '0;
            r_elapsed <= '0;
            r_raw     <= '0;
            r_prev    <= '0;
            for (int i = 0; i < FRAME_BYTES; i++) r_store[i] <= 8'h00;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_elapsed <= n_elapsed;
            r_raw     <= n_raw;
            r_prev    <= n_prev;
            r_store   <= n_store;
        end
    end

    // Reconfiguration limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

endmodule

`default_nettype wire

[rtl/gps_out_buf.sv]
// Result register with one skid entry, so the input side can take one more
// item while the receiver stalls. Depends on gps_pkg.
`default_nettype none

module gps_out_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire gps_pkg::t_out_item i_data,
    output logic                    o_full,
    output logic                    o_valid,
    output gps_pkg::t_out_item      o_data,
    input  wire logic               i_stall
);
    import gps_pkg::*;

    logic      r_out_valid, n_out_valid;
    logic      r_skid_valid, n_skid_valid;
    t_out_item r_out, n_out;
    t_out_item r_skid, n_skid;
    logic      out_free;

    // Refill the output register from skid first, then from the push
    always_comb begin
        out_free     = !r_out_valid || !i_stall;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = i_data;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench for gamepad_poll_sequencer_unit: directed frames, limit boundary, random traffic.
// Tracks the sequencer in a behavioral copy and checks every status transfer against it.
// Depends on gps_pkg and the RTL of the block.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gps_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int LIMIT_TICKS   = 40;

    // Command strings shifted out during the configuration phases
    localparam logic [0:4][7:0] ENTER_CFG_BYTES = {8'h01, 8'h43, 8'h00, 8'h01, 8'h00};
    localparam logic [0:8][7:0] SET_MODE_BYTES  = {8'h01, 8'h44, 8'h00, 8'h01, 8'h03,
                                                   8'h00, 8'h00, 8'h00, 8'h00};
    localparam logic [0:8][7:0] EXIT_CFG_BYTES  = {8'h01, 8'h43, 8'h00, 8'h00, 8'h5A,
                                                   8'h5A, 8'h5A, 8'h5A, 8'h5A};
    localparam logic [7:0] LEAD_BYTE = 8'h01;
    localparam logic [7:0] POLL_REQ  = 8'h42;

    // Short frame used by the directed test: buttons low byte 0x00, high byte 0xFF
    localparam logic [0:8][7:0] SAMPLE_FRAME = {8'hFF, 8'h41, 8'h5A, 8'h00, 8'hFF,
                                                8'h12, 8'h34, 8'h56, 8'h78};

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int fail_count    = 0;
    int cycle_count   = 0;

    // Behavioral copy of the sequencer state
    t_phase      seq_phase;
    logic [4:0]  seq_pos;
    logic [7:0]  frame_copy [FRAME_BYTES];
    logic [15:0] idle_ms;
    logic [15:0] buttons_raw;
    logic [15:0] buttons_prev;
    logic [15:0] limit_ms;

    t_out_item status_q[$];

    gamepad_poll_sequencer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("t=%0t %s", $time, msg);
    endfunction

    function automatic void field_check(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
            note_failure($sformatf("%s: expected %h, got %h", name, want, got));
    endfunction

    function automatic t_in_item make_item(t_cmd c, logic [7:0] rx, logic [4:0] idx);
        t_in_item it;
        it.cmd     = c;
        it.rx_byte = rx;
        it.index   = idx;
        return it;
    endfunction

    function automatic void reset_copy();
        seq_phase    = PH_IDLE;
        seq_pos      = '0;
        idle_ms      = '0;
        buttons_raw  = '0;
        buttons_prev = '0;
        limit_ms     = LIMIT_RESET;
        foreach (frame_copy[k]) frame_copy[k] = 8'h00;
    endfunction

    // Length of the string being sent; poll frame grows once a full-mode byte is in
    function automatic int string_len();
        case (seq_phase)
            PH_ENTER:            return ENTER_LEN;
            PH_SETMODE, PH_EXIT: return CFG_LEN;
            PH_POLL:             return (seq_pos >= MODE_KNOWN &&
                                         frame_copy[MODE_BYTE] == MODE_FULL) ?
                                        FRAME_BYTES : SHORT_FRAME;
            default:             return 0;
        endcase
    endfunction

    function automatic logic [7:0] command_byte();
        case (seq_phase)
            PH_ENTER:   return (seq_pos < ENTER_LEN) ? ENTER_CFG_BYTES[seq_pos] : 8'h00;
            PH_SETMODE: return (seq_pos < CFG_LEN) ? SET_MODE_BYTES[seq_pos] : 8'h00;
            PH_EXIT:    return (seq_pos < CFG_LEN) ? EXIT_CFG_BYTES[seq_pos] : 8'h00;
            PH_POLL:    return (seq_pos == 5'd0) ? LEAD_BYTE :
                               (seq_pos == 5'd1) ? POLL_REQ : 8'h00;
            default:    return 8'h00;
        endcase
    endfunction

    function automatic void open_poll_string();
        buttons_prev = buttons_raw;
        seq_phase    = PH_POLL;
        seq_pos      = '0;
    endfunction

    // Advance the copy by one accepted command and queue the status it yields
    function automatic void track_sequencer(t_in_item item);
        t_out_item   st;
        logic [7:0]  rd;
        logic        done;
        logic        busy;
        logic [15:0] chg;
        rd   = 8'h00;
        done = 1'b0;
        case (item.cmd)
            CMD_TICK: begin
                if (idle_ms != 16'hFFFF) idle_ms = idle_ms + 16'd1;
            end
            CMD_POLL: begin
                if (seq_phase == PH_IDLE) begin
                    if (idle_ms > limit_ms) begin
                        seq_phase = PH_ENTER;
                        seq_pos   = '0;
                    end else begin
                        open_poll_string();
                    end
                end
            end
            CMD_XCHG: begin
                if (seq_phase != PH_IDLE) begin
                    if (seq_phase == PH_POLL && seq_pos < FRAME_BYTES)
                        frame_copy[seq_pos] = item.rx_byte;
                    seq_pos = seq_pos + 5'd1;
                    if (seq_pos >= string_len()) begin
                        case (seq_phase)
                            PH_ENTER: begin
                                seq_phase = PH_SETMODE;
                                seq_pos   = '0;
                            end
                            PH_SETMODE: begin
                                seq_phase = PH_EXIT;
                                seq_pos   = '0;
                            end
                            PH_EXIT: open_poll_string();
                            default: begin
                                buttons_raw = {frame_copy[BTN_HI_BYTE], frame_copy[BTN_LO_BYTE]};
                                idle_ms     = '0;
                                seq_phase   = PH_IDLE;
                                seq_pos     = '0;
                                done        = 1'b1;
                            end
                        endcase
                    end
                end
            end
            default: begin
                if (item.index < FRAME_BYTES) rd = frame_copy[item.index];
            end
        endcase

        busy = (seq_phase != PH_IDLE);
        chg  = buttons_prev ^ buttons_raw;
        st.tx_byte       = busy ? command_byte() : 8'h00;
        st.attention     = busy;
        st.release_after = busy && (int'(seq_pos) + 1 == string_len());
        st.frame_done    = done;
        st.held_mask     = ~buttons_raw;
        st.pressed_mask  = chg & ~buttons_raw;
        st.released_mask = chg & ~buttons_prev;
        st.mode_id       = frame_copy[MODE_BYTE];
        st.read_data     = rd;
        status_q.push_back(st);
    endfunction

    function automatic void compare_status(t_out_item want, t_out_item got);
        field_check("tx_byte", want.tx_byte, got.tx_byte);
        field_check("attention", want.attention, got.attention);
        field_check("release_after", want.release_after, got.release_after);
        field_check("frame_done", want.frame_done, got.frame_done);
        field_check("held_mask", want.held_mask, got.held_mask);
        field_check("pressed_mask", want.pressed_mask, got.pressed_mask);
        field_check("released_mask", want.released_mask, got.released_mask);
        field_check("mode_id", want.mode_id, got.mode_id);
        field_check("read_data", want.read_data, got.read_data);
    endfunction

    // Status side: random stall, check each transfer against the oldest queued status
    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < out_stall_pct);
        if (out_valid === 1'b1 && !out_stall) begin
            if (status_q.size() == 0)
                note_failure("status transfer with nothing outstanding");
            else
                compare_status(status_q.pop_front(), out_data);
        end
    end

    // Command side: optional idle gap, then hold the item until transfer
    task automatic send_command(input t_in_item item);
        int gap;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        track_sequencer(item);
    endtask

    // Limit write only with the pipe drained
    task automatic write_limit(input logic [15:0] value);
        in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        limit_ms  = value;
    endtask

    // Reads at the edges, ignored commands, one short frame with a read in the middle
    task automatic test_short_frame();
        send_idle_pct = 0;
        out_stall_pct = 0;
        send_command(make_item(CMD_READ, 8'h00, 5'd0));
        send_command(make_item(CMD_READ, 8'hFF, 5'd31));
        send_command(make_item(CMD_XCHG, 8'hFF, 5'd0));   // idle: byte dropped
        send_command(make_item(CMD_TICK, 8'h00, 5'd0));
        send_command(make_item(CMD_POLL, 8'h00, 5'd0));
        send_command(make_item(CMD_POLL, 8'hFF, 5'd31));  // busy: ignored
        for (int k = 0; k < SHORT_FRAME; k++) begin
            send_command(make_item(CMD_XCHG, SAMPLE_FRAME[k], 5'd0));
            if (k == 2) send_command(make_item(CMD_READ, 8'h00, 5'd1));
        end
        send_command(make_item(CMD_READ, 8'h00, 5'd3));
        send_command(make_item(CMD_READ, 8'h00, 5'd20));
        send_command(make_item(CMD_READ, 8'h00, 5'd21));
    endtask

    // Idle count equal to the limit polls straight out,
    // one tick past the limit triggers reconfiguration
    task automatic test_limit_boundary();
        send_idle_pct = 0;
        out_stall_pct = 0;
        for (int pass = 0; pass < 2; pass++) begin
            write_limit(pass == 0 ? 16'(LIMIT_TICKS) : 16'(LIMIT_TICKS - 1));
            repeat (LIMIT_TICKS) send_command(make_item(CMD_TICK, 8'h00, 5'd0));
            send_command(make_item(CMD_POLL, 8'h00, 5'd0));
            while (seq_phase != PH_IDLE)
                send_command(make_item(CMD_XCHG, 8'($urandom_range(255)),
                                       5'($urandom_range(31))));
        end
    endtask

    // Mostly well-formed polls with random content, plus ticks, reads and noise
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct, input logic [15:0] limit);
        t_in_item item;
        int       useful;
        int       pick;
        write_limit(limit);
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        useful = 0;
        while (useful < n_items) begin
            pick = $urandom_range(99);
            if (seq_phase == PH_IDLE)
                item.cmd = (pick < 45) ? CMD_TICK : (pick < 80) ? CMD_POLL :
                           (pick < 90) ? CMD_READ : CMD_XCHG;
            else
                item.cmd = (pick < 75) ? CMD_XCHG : (pick < 85) ? CMD_TICK :
                           (pick < 93) ? CMD_READ : CMD_POLL;
            // favor the full-mode byte where the frame length is decided
            if (seq_phase == PH_POLL && seq_pos == MODE_BYTE && $urandom_range(1) == 1)
                item.rx_byte = MODE_FULL;
            else
                item.rx_byte = 8'($urandom_range(255));
            item.index = 5'($urandom_range(31));
            if (!(item.cmd == CMD_XCHG && seq_phase == PH_IDLE) &&
                !(item.cmd == CMD_POLL && seq_phase != PH_IDLE))
                useful++;
            send_command(item);
        end
    endtask

    initial begin
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        i_rst_n   <= 1'b0;
        reset_copy();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_frame();
        test_limit_boundary();
        test_random_traffic(380, 0, 0, 16'd0);
        test_random_traffic(380, 49, 0, 16'hFFFF);
        test_random_traffic(380, 0, 49, 16'($urandom_range(1, 6)));
        test_random_traffic(380, 31, 31, 16'($urandom_range(0, 65535)));

        // drain and settle
        in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[gamepad_poll_sequencer_unit.f]
rtl/gps_pkg.sv
rtl/gps_core.sv
rtl/gps_out_buf.sv
rtl/gamepad_poll_sequencer_unit.sv
sim/tb_top.sv
